[hdl/gmps_pkg.sv]
// Shared types and constants for the grid minimum path sum block.
// Depends on nothing; every other file but gmps_row_ram imports it.
package gmps_pkg;

  localparam int MAX_COLS = 2048;
  localparam int MAX_ROWS = 2048;

  localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SIZE_W  = 12;  // configuration register width
  localparam int CNT_W   = 13;  // room for sizes up to 4096
  localparam int VALUE_W = 11;
  localparam int COST_W  = 24;
  localparam int SUM_W   = 23;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } cfg_reg_t;

  // Position flags of one cell, handed from sequencer to cost unit
  typedef struct packed {
    logic row0;
    logic col0;
    logic last;
  } cell_ctl_t;

endpackage

[hdl/gmps_row_ram.sv]
// Single-port-write, registered-read RAM holding one row of path costs.
// Generic; no package dependency.
module gmps_row_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/gmps_seq.sv]
// Configuration registers and raster position counters.
// Depends on gmps_pkg.
module gmps_seq
  import gmps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  input  logic                 accept,
  output logic [COL_W-1:0]     col_addr,
  output cell_ctl_t            ctl
);

  logic [SIZE_W-1:0] grid_rows;
  logic [SIZE_W-1:0] grid_cols;
  logic [COL_W-1:0]  col_index;
  logic [ROW_W-1:0]  row_index;
  logic [CNT_W-1:0]  rows_eff;
  logic [CNT_W-1:0]  cols_eff;
  logic [CNT_W-1:0]  col_plus;
  logic [CNT_W-1:0]  row_plus;
  logic              last_col;
  logic              last_row;

  // Zero acts as one, oversize acts as the maximum
  always_comb begin
    if (grid_rows == '0) begin
      rows_eff = CNT_W'(1);
    end else if (CNT_W'(grid_rows) > CNT_W'(MAX_ROWS)) begin
      rows_eff = CNT_W'(MAX_ROWS);
    end else begin
      rows_eff = CNT_W'(grid_rows);
    end
    if (grid_cols == '0) begin
      cols_eff = CNT_W'(1);
    end else if (CNT_W'(grid_cols) > CNT_W'(MAX_COLS)) begin
      cols_eff = CNT_W'(MAX_COLS);
    end else begin
      cols_eff = CNT_W'(grid_cols);
    end
  end

  assign col_plus = CNT_W'(col_index) + CNT_W'(1);
  assign row_plus = CNT_W'(row_index) + CNT_W'(1);
  assign last_col = col_plus >= cols_eff;
  assign last_row = row_plus >= rows_eff;

  assign col_addr = col_index;
  assign ctl.row0 = (row_index == '0);
  assign ctl.col0 = (col_index == '0);
  assign ctl.last = last_col && last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= SIZE_W'(1);
      grid_cols <= SIZE_W'(1);
      col_index <= '0;
      row_index <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROWS: grid_rows <= cfg_data;
        REG_COLS: grid_cols <= cfg_data;
      endcase
      col_index <= '0;
      row_index <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_index <= '0;
        row_index <= last_row ? '0 : row_plus[ROW_W-1:0];
      end else begin
        col_index <= col_plus[COL_W-1:0];
      end
    end
  end

endmodule

[hdl/gmps_cost.sv]
// Cost stage: forms each cell's path cost from the row buffer and the left
// cost, writes it back, and holds the result register. Depends on gmps_pkg.
module gmps_cost
  import gmps_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clear,
  input  logic                      accept,
  input  logic signed [VALUE_W-1:0] cell_value,
  input  logic [COL_W-1:0]          col_addr,
  input  cell_ctl_t                 ctl,
  input  logic [COST_W-1:0]         rd_data,
  output logic                      wr_en,
  output logic [COL_W-1:0]          wr_addr,
  output logic [COST_W-1:0]         wr_data,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SUM_W-1:0]   min_sum
);

  logic                      s1_valid;
  cell_ctl_t                 s1_ctl;
  logic [COL_W-1:0]          s1_addr;
  logic signed [VALUE_W-1:0] s1_value;
  logic                      fwd_hit;
  logic signed [COST_W-1:0]  fwd_data;
  logic signed [COST_W-1:0]  left_cost;
  logic signed [COST_W-1:0]  up;
  logic signed [COST_W-1:0]  base;
  logic signed [COST_W-1:0]  cost;
  logic                      s1_adv;

  // Take the entry just written when the read raced the write
  assign up = fwd_hit ? fwd_data : $signed(rd_data);

  always_comb begin
    if (s1_ctl.row0) begin
      base = s1_ctl.col0 ? '0 : left_cost;
    end else if (s1_ctl.col0) begin
      base = up;
    end else begin
      base = (up < left_cost) ? up : left_cost;
    end
    cost = base + COST_W'(s1_value);
  end

  // Stall only a last cell whose result has nowhere to go
  assign s1_adv   = s1_valid && (!s1_ctl.last || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  assign wr_en   = s1_adv;
  assign wr_addr = s1_addr;
  assign wr_data = cost;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl   <= ctl;
      s1_addr  <= col_addr;
      s1_value <= cell_value;
      fwd_hit  <= s1_adv && (s1_addr == col_addr);
      fwd_data <= cost;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      left_cost <= '0;
    end else if (s1_adv) begin
      left_cost <= s1_ctl.last ? '0 : cost;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_ctl.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_ctl.last) begin
      min_sum <= cost[SUM_W-1:0];
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_addr) && $stable(s1_value))
    else $error("stalled cost stage lost its cell");

  a_last_lands: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_ctl.last |=> out_valid)
    else $error("last cell did not load a result");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_ctl.last))
    else $error("result appeared without a last cell");

  a_no_wr_idle: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> s1_valid)
    else $error("row buffer written with no cell in flight");

endmodule

[hdl/grid_min_path_sum_top.sv]
// Top level of the grid minimum path sum block.
// Depends on gmps_pkg, gmps_seq, gmps_row_ram and gmps_cost.
//
// Usage:
//   Input channel (in_valid/in_ready, cell_value) carries one signed grid
//   cell per transfer in row-major order. Output channel (out_valid/
//   out_ready, min_sum) carries one transfer per grid: the minimum path sum
//   from the top-left to the bottom-right cell, after the grid's last cell.
//   Configuration: cfg_we writes cfg_data into grid_rows (index 0) or
//   grid_cols (index 1) at the clock edge; a size of 0 acts as 1 and a size
//   above the maximum acts as the maximum. A write restarts the grid. Write
//   only while no cell is in flight.
// Throughput: one cell per cycle while no last cell is held by a waiting result; the
//   row buffer is one RAM with one write and one registered read port, read at accept
//   and written when the cell leaves the cost stage, with the freshly written cost
//   forwarded when both hit the same column.
// Result: out_valid is registered, set when the last cell leaves the cost stage.
// Reset: rst (synchronous) sets both sizes to 1 and starts a new grid; the
//   row buffer needs no clearing since row 0 writes each entry first.
// Stall: while a result waits on out_ready, cells keep transferring; only a
//   further last cell holds in the cost stage, and in_ready drops then.
module grid_min_path_sum_top
  import gmps_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [SIZE_W-1:0]         cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [VALUE_W-1:0] cell_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SUM_W-1:0]   min_sum
);

  logic              accept;
  logic [COL_W-1:0]  col_addr;
  cell_ctl_t         ctl;
  logic [COST_W-1:0] rd_data;
  logic              wr_en;
  logic [COL_W-1:0]  wr_addr;
  logic [COST_W-1:0] wr_data;

  // A cell transfers when both sides agree
  assign accept = in_valid && in_ready;

  // Sizes and raster position
  gmps_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .col_addr  (col_addr),
    .ctl       (ctl)
  );

  // One row of partial path costs, read at transfer time
  gmps_row_ram #(
    .DEPTH (MAX_COLS),
    .WIDTH (COST_W)
  ) u_row_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Add and compare, write back, and hold the result
  gmps_cost u_cost (
    .clk        (clk),
    .rst        (rst),
    .clear      (cfg_we),
    .accept     (accept),
    .cell_value (cell_value),
    .col_addr   (col_addr),
    .ctl        (ctl),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .min_sum    (min_sum)
  );

endmodule

[verif/grid_min_path_sum_tb.sv]
// Self-checking bench for grid_min_path_sum_top: streams signed grid cells in raster order
// and compares every minimum path sum against an in-bench model of the cost recurrence.
// Depends on gmps_pkg and grid_min_path_sum_top.
module testbench;
  import gmps_pkg::*;

  // Cycles allowed for a cell to clear the cost stage once no result is due, with ample
  // slack.
  localparam int SETTLE_CYCLES = 8;
  // Long receiver hold-off, long enough to back the block up into in_ready.
  localparam int HOLD_CYCLES   = 300;
  // Worst correct run: about 550 cells, a few hundred sums waiting on out_ready, the
  // hold-off and the settling around some forty size writes; allow several times the
  // total.
  localparam int CYCLE_LIMIT   = 400_000;

  // Model of the block: one row of partial path costs plus the cost to the left.
  // Accepted cells advance it and completed grids queue the sums the block owes.
  class path_sum_board;
    logic [SIZE_W-1:0]       rows_reg;
    logic [SIZE_W-1:0]       cols_reg;
    int                      row_cost [MAX_COLS];
    int                      left;
    int unsigned             col_pos;
    int unsigned             row_pos;
    logic signed [SUM_W-1:0] sums_due [$];
    int                      errors;
    int                      cells;
    int                      sums_checked;
    int                      abandoned;
    int                      size_writes;

    function new();
      rows_reg = 1;
      cols_reg = 1;
      left     = 0;
      col_pos  = 0;
      row_pos  = 0;
      foreach (row_cost[i]) row_cost[i] = 0;
    endfunction

    // A size of 0 acts as 1 and anything above the maximum acts as the maximum
    static function int unsigned eff_size(logic [SIZE_W-1:0] v, int unsigned cap);
      if (v == 0) return 1;
      if (v > cap) return cap;
      return v;
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("ERROR: %s", what);
    endfunction

    // Any size write drops the grid in progress and starts over at the top-left cell
    function void set_size(cfg_reg_t idx, logic [SIZE_W-1:0] v);
      if (row_pos != 0 || col_pos != 0) abandoned++;
      if (idx == REG_ROWS) rows_reg = v;
      else cols_reg = v;
      size_writes++;
      col_pos = 0;
      row_pos = 0;
      left    = 0;
    endfunction

    function void advance_cell(logic signed [VALUE_W-1:0] v);
      int unsigned nrows;
      int unsigned ncols;
      int          cost;
      nrows = eff_size(rows_reg, MAX_ROWS);
      ncols = eff_size(cols_reg, MAX_COLS);
      cells++;
      // Top row and left column are plain running sums; elsewhere take the cheaper
      // of the cell above and the cell to the left.
      if (row_pos == 0 && col_pos == 0) cost = v;
      else if (row_pos == 0) cost = left + v;
      else if (col_pos == 0) cost = row_cost[0] + v;
      else cost = v + ((row_cost[col_pos] < left) ? row_cost[col_pos] : left);
      row_cost[col_pos] = cost;
      left = cost;
      if (col_pos + 1 >= ncols) begin
        col_pos = 0;
        if (row_pos + 1 >= nrows) begin
          row_pos = 0;
          left    = 0;
          sums_due.push_back(cost[SUM_W-1:0]);
        end else begin
          row_pos++;
        end
      end else begin
        col_pos++;
      end
    endfunction

    function void match_sum(logic signed [SUM_W-1:0] got);
      logic signed [SUM_W-1:0] want;
      if (sums_due.size() == 0) begin
        flag($sformatf("unexpected min_sum %0d with no grid completed", got));
        return;
      end
      want = sums_due.pop_front();
      sums_checked++;
      if (got !== want)
        flag($sformatf("min_sum mismatch: expected %0d, got %0d", want, got));
    endfunction

    function int pending();
      return sums_due.size();
    endfunction

    function void wrap_up();
      if (sums_due.size() != 0)
        flag($sformatf("%0d grid sums never arrived", sums_due.size()));
      errors += (sums_due.size() > 1) ? sums_due.size() - 1 : 0;
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [SIZE_W-1:0]         cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [VALUE_W-1:0] cell_value;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [SUM_W-1:0]   min_sum;

  path_sum_board board;
  bit            quiet_sender;   // no gaps between cells while set
  bit            hold_request;   // ask the receiver for one long hold-off
  bit            hold_active;
  int            cycle_count;
  int            input_stalls;

  grid_min_path_sum_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cell_value (cell_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .min_sum    (min_sum)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watch both channels and the size port at every edge. Values read here are the ones
  // from before the edge, because all drivers use nonblocking assignments.
  always @(posedge clk) begin
    if (!rst && board != null) begin
      if (cfg_we) board.set_size(cfg_reg_t'(cfg_index), cfg_data);
      if (in_valid && in_ready) board.advance_cell(cell_value);
      if (in_valid && !in_ready) input_stalls++;
      if (out_valid && out_ready) board.match_sum(min_sum);
    end
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("grid_min_path_sum_top test failed");
      $finish;
    end
  end

  // Mostly back-to-back, often a short gap, now and then a long one
  function automatic int pick_gap();
    int roll;
    if (quiet_sender) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Mostly in range, sometimes any 11-bit pattern so every bit toggles both ways
  function automatic int rand_cell();
    if ($urandom_range(0, 99) < 15) return int'($urandom_range(0, 2047)) - 1024;
    return int'($urandom_range(0, 2000)) - 1000;
  endfunction

  // Receiver: ready for random stretches, stalled for random stretches, and once held
  // off long enough for the block to back up into its input.
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_active  = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
      end
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < 80) repeat ($urandom_range(1, 12)) @(posedge clk);
      else repeat ($urandom_range(40, 150)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Offer one cell and hold it until the transfer. Valid stays high afterwards so the
  // next cell can follow with no gap.
  task automatic push_cell(input int v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cell_value <= v[VALUE_W-1:0];
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic park();
    in_valid <= 1'b0;
  endtask

  task automatic send_random(input int count);
    repeat (count) push_cell(rand_cell());
    park();
  endtask

  // Wait for every owed sum, then let any trailing cell of a partial grid drain
  task automatic wait_idle();
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(input cfg_reg_t idx, input logic [SIZE_W-1:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Write both sizes, then send whole grids and an optional partial one that the next
  // size write abandons.
  task automatic run_phase(input logic [SIZE_W-1:0] r, input logic [SIZE_W-1:0] c,
                           input int grids, input int partial);
    int per_grid;
    set_size(REG_ROWS, r);
    set_size(REG_COLS, c);
    per_grid = path_sum_board::eff_size(r, MAX_ROWS) * path_sum_board::eff_size(c, MAX_COLS);
    send_random(grids * per_grid + partial);
  endtask

  initial begin
    int unit_vals [6]    = '{1023, -1024, 1000, -1000, 0, -1};
    int classic_vals [9] = '{1, 3, 1, 1, 5, 1, 4, 2, 1};
    int r;
    int c;
    int per_grid;
    int partial;

    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = REG_ROWS;
    cfg_data   = '0;
    in_valid   = 1'b0;
    cell_value = '0;
    board      = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset size is 1x1: every cell is its own grid; hit the sign extremes
    foreach (unit_vals[i]) push_cell(unit_vals[i]);
    park();

    // 3x3 grid where the cheap path turns both right and down
    set_size(REG_ROWS, 3);
    set_size(REG_COLS, 3);
    foreach (classic_vals[i]) push_cell(classic_vals[i]);
    park();

    // Zero rows act as one row, then zero columns as one column
    set_size(REG_ROWS, 0);
    repeat (3) push_cell(-1024);
    park();
    set_size(REG_COLS, 0);
    push_cell(7);
    park();

    // Abandon a 2x2 grid three cells in; rewriting the same size restarts it
    set_size(REG_ROWS, 2);
    set_size(REG_COLS, 2);
    push_cell(1000);
    push_cell(-1000);
    push_cell(500);
    park();
    set_size(REG_COLS, 2);
    push_cell(-7);
    push_cell(1023);
    push_cell(-1024);
    push_cell(3);
    park();

    // 1x1 grids against a long receiver hold-off: fill the block and stall its input
    set_size(REG_ROWS, 1);
    set_size(REG_COLS, 1);
    hold_request = 1'b1;
    wait (hold_active);
    quiet_sender = 1'b1;
    send_random(60);
    quiet_sender = 1'b0;

    // Small random shapes, some ending in a partial grid
    for (int k = 0; k < 12; k++) begin
      r = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
      c = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      per_grid = path_sum_board::eff_size(SIZE_W'(r), MAX_ROWS) *
                 path_sum_board::eff_size(SIZE_W'(c), MAX_COLS);
      partial  = (k % 3 == 0 && per_grid > 1) ? $urandom_range(1, per_grid - 1) : 0;
      run_phase(SIZE_W'(r), SIZE_W'(c), (20 + per_grid - 1) / per_grid, partial);
    end

    // Largest sizes; oversize values clamp to the maximum. Grids this big are only
    // started here, then abandoned by the next size write.
    run_phase(4095, 0, 0, 20);
    run_phase(0, 4095, 0, 20);
    quiet_sender = 1'b1;
    run_phase(2, 2048, 0, 30);
    quiet_sender = 1'b0;
    run_phase(4095, 4095, 0, 30);

    // Finish on an ordinary shape after abandoning the oversize grid
    run_phase(3, 5, 4, 0);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    board.wrap_up();

    $display("Covered %0d cells and %0d grid sums over %0d size writes (%0d grids abandoned).",
             board.cells, board.sums_checked, board.size_writes, board.abandoned);
    $display("Sizes from 0 to 4095 per register; input held by back-pressure for %0d cycles.",
             input_stalls);
    if (board.errors == 0) begin
      $display("grid_min_path_sum_top test passed");
    end else begin
      $display("%0d failures", board.errors);
      $display("grid_min_path_sum_top test failed");
    end
    $finish;
  end

endmodule
